>>> sv/nwr_pkg.sv
// ----------------------------------------------------------------------------
// nwr_pkg
// Types, constants and matrix-pattern functions shared by the net-wrench
// regressor modules.
// ----------------------------------------------------------------------------
package nwr_pkg;

   localparam int NUM_COLS  = 10;
   localparam int NUM_SLOTS = 4;

   typedef logic signed [31:0] fix_type;
   typedef fix_type [2:0] vec3_type;
   typedef fix_type [NUM_COLS-1:0] mrow_type;

   localparam fix_type FIX_MAX = 32'sh7fff_ffff;
   localparam fix_type FIX_MIN = 32'sh8000_0000;

   // row numbers of the regressor and of the 6-row patterns
   localparam logic [2:0] ROW_FX = 3'd0;
   localparam logic [2:0] ROW_FY = 3'd1;
   localparam logic [2:0] ROW_FZ = 3'd2;
   localparam logic [2:0] ROW_TX = 3'd3;
   localparam logic [2:0] ROW_TY = 3'd4;
   localparam logic [2:0] ROW_TZ = 3'd5;

   localparam int COL_MASS = 0;
   localparam int COL_MCX  = 1;
   localparam int COL_MCY  = 2;
   localparam int COL_MCZ  = 3;
   localparam int COL_IXX  = 4;
   localparam int COL_IXY  = 5;
   localparam int COL_IXZ  = 6;
   localparam int COL_IYY  = 7;
   localparam int COL_IYZ  = 8;
   localparam int COL_IZZ  = 9;

   typedef struct packed {
      fix_type lin_vel_x;
      fix_type lin_vel_y;
      fix_type lin_vel_z;
      fix_type ang_vel_x;
      fix_type ang_vel_y;
      fix_type ang_vel_z;
      fix_type lin_acc_x;
      fix_type lin_acc_y;
      fix_type lin_acc_z;
      fix_type ang_acc_x;
      fix_type ang_acc_y;
      fix_type ang_acc_z;
   } req_type;

   typedef struct packed {
      logic [2:0] row_index;
      logic       last_row;
      fix_type    coef_mass;
      fix_type    coef_mcx;
      fix_type    coef_mcy;
      fix_type    coef_mcz;
      fix_type    coef_ixx;
      fix_type    coef_ixy;
      fix_type    coef_ixz;
      fix_type    coef_iyy;
      fix_type    coef_iyz;
      fix_type    coef_izz;
   } rsp_type;

   // nonzero entries of one row of the motion cross product matrix
   typedef struct packed {
      logic [NUM_SLOTS-1:0][2:0] kidx;
      fix_type [NUM_SLOTS-1:0]   xval;
   } slot_type;

   // one row to be multiplied out
   typedef struct packed {
      logic [2:0]                row_index;
      fix_type [NUM_SLOTS-1:0]   xval;
      mrow_type [NUM_SLOTS-1:0]  opnd;
      mrow_type                  base;
   } op_type;

   typedef struct packed {
      logic [2:0] row_index;
      mrow_type   base;
   } row_info_type;

   function automatic fix_type neg_sat(fix_type x);
      return (x == FIX_MIN) ? FIX_MAX : -x;
   endfunction

   // one row of the 6x10 pattern M(t) for linear part l and angular part w
   function automatic mrow_type build_m_row(vec3_type l, vec3_type w, logic [2:0] r);
      mrow_type m;
      m = '0;
      unique case (r)
         ROW_FX: begin
            m[COL_MASS] = l[0];
            m[COL_MCY]  = neg_sat(w[2]);
            m[COL_MCZ]  = w[1];
         end
         ROW_FY: begin
            m[COL_MASS] = l[1];
            m[COL_MCX]  = w[2];
            m[COL_MCZ]  = neg_sat(w[0]);
         end
         ROW_FZ: begin
            m[COL_MASS] = l[2];
            m[COL_MCX]  = neg_sat(w[1]);
            m[COL_MCY]  = w[0];
         end
         ROW_TX: begin
            m[COL_MCY] = l[2];
            m[COL_MCZ] = neg_sat(l[1]);
            m[COL_IXX] = w[0];
            m[COL_IXY] = w[1];
            m[COL_IXZ] = w[2];
         end
         ROW_TY: begin
            m[COL_MCX] = neg_sat(l[2]);
            m[COL_MCZ] = l[0];
            m[COL_IXY] = w[0];
            m[COL_IYY] = w[1];
            m[COL_IYZ] = w[2];
         end
         ROW_TZ: begin
            m[COL_MCX] = l[1];
            m[COL_MCY] = neg_sat(l[0]);
            m[COL_IXZ] = w[0];
            m[COL_IYZ] = w[1];
            m[COL_IZZ] = w[2];
         end
         default: m = '0;
      endcase
      return m;
   endfunction

   // nonzero entries of row r of the cross product matrix, ascending column
   function automatic slot_type row_slots(vec3_type u, vec3_type w, logic [2:0] r);
      slot_type s;
      s.kidx = '0;
      s.xval = '0;
      unique case (r)
         ROW_FX: begin
            s.kidx[0] = ROW_FY; s.xval[0] = neg_sat(w[2]);
            s.kidx[1] = ROW_FZ; s.xval[1] = w[1];
         end
         ROW_FY: begin
            s.kidx[0] = ROW_FX; s.xval[0] = w[2];
            s.kidx[1] = ROW_FZ; s.xval[1] = neg_sat(w[0]);
         end
         ROW_FZ: begin
            s.kidx[0] = ROW_FX; s.xval[0] = neg_sat(w[1]);
            s.kidx[1] = ROW_FY; s.xval[1] = w[0];
         end
         ROW_TX: begin
            s.kidx[0] = ROW_FY; s.xval[0] = neg_sat(u[2]);
            s.kidx[1] = ROW_FZ; s.xval[1] = u[1];
            s.kidx[2] = ROW_TY; s.xval[2] = neg_sat(w[2]);
            s.kidx[3] = ROW_TZ; s.xval[3] = w[1];
         end
         ROW_TY: begin
            s.kidx[0] = ROW_FX; s.xval[0] = u[2];
            s.kidx[1] = ROW_FZ; s.xval[1] = neg_sat(u[0]);
            s.kidx[2] = ROW_TX; s.xval[2] = w[2];
            s.kidx[3] = ROW_TZ; s.xval[3] = neg_sat(w[0]);
         end
         ROW_TZ: begin
            s.kidx[0] = ROW_FX; s.xval[0] = neg_sat(u[1]);
            s.kidx[1] = ROW_FY; s.xval[1] = u[0];
            s.kidx[2] = ROW_TX; s.xval[2] = neg_sat(w[1]);
            s.kidx[3] = ROW_TY; s.xval[3] = w[0];
         end
         default: begin
            s.kidx = '0;
            s.xval = '0;
         end
      endcase
      return s;
   endfunction

endpackage

>>> sv/nwr_issue.sv
// ----------------------------------------------------------------------------
// nwr_issue
// Holds the accepted item and steps through its six rows, forming the
// multiplier operands and the acceleration base row for each.
// ----------------------------------------------------------------------------
module nwr_issue import nwr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    op_valid,
   input  logic    op_ready,
   output op_type  op_data
);

   logic       a_valid_ff, a_valid_in;
   req_type    item_ff, item_in;
   logic [2:0] row_ff, row_in;

   vec3_type   u, w, p, q;
   slot_type   slot;
   logic       fire, last, accept;

   assign u = {item_ff.lin_vel_z, item_ff.lin_vel_y, item_ff.lin_vel_x};
   assign w = {item_ff.ang_vel_z, item_ff.ang_vel_y, item_ff.ang_vel_x};
   assign p = {item_ff.lin_acc_z, item_ff.lin_acc_y, item_ff.lin_acc_x};
   assign q = {item_ff.ang_acc_z, item_ff.ang_acc_y, item_ff.ang_acc_x};

   assign last      = (row_ff == ROW_TZ);
   assign fire      = a_valid_ff && op_ready;
   assign req_stall = a_valid_ff && !(op_ready && last);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      slot              = row_slots(u, w, row_ff);
      op_data.row_index = row_ff;
      op_data.xval      = slot.xval;
      op_data.base      = build_m_row(p, q, row_ff);
      for (int s = 0; s < NUM_SLOTS; s++) begin
         op_data.opnd[s] = build_m_row(u, w, slot.kidx[s]);
      end
   end

   assign op_valid = a_valid_ff;

   always_comb begin
      a_valid_in = a_valid_ff;
      row_in     = row_ff;
      item_in    = item_ff;
      if (fire) begin
         row_in = last ? ROW_FX : row_ff + 3'd1;
         if (last) begin
            a_valid_in = 1'b0;
         end
      end
      if (accept) begin
         a_valid_in = 1'b1;
         item_in    = req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         row_ff     <= ROW_FX;
      end else begin
         a_valid_ff <= a_valid_in;
         row_ff     <= row_in;
      end
      item_ff <= item_in;
   end

endmodule

>>> sv/nwr_mult.sv
// ----------------------------------------------------------------------------
// nwr_mult
// Multiplier array for one row: each cross product entry times its pattern
// row, floored by the fraction shift and registered.
// ----------------------------------------------------------------------------
module nwr_mult import nwr_pkg::*; #(
   parameter int FRAC_BITS = 16,
   localparam int PW = 64 - FRAC_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   op_valid,
   output logic                                   op_ready,
   input  op_type                                 op_data,
   output logic                                   prod_valid,
   input  logic                                   prod_ready,
   output row_info_type                           prod_info,
   output logic [NUM_SLOTS-1:0][NUM_COLS-1:0][PW-1:0] prod_data
);

   logic                                       prod_valid_ff;
   row_info_type                               info_ff, info_in;
   logic [NUM_SLOTS-1:0][NUM_COLS-1:0][PW-1:0] prod_ff, prod_in;

   logic signed [63:0] full [NUM_SLOTS][NUM_COLS];
   logic signed [63:0] shf  [NUM_SLOTS][NUM_COLS];

   assign op_ready = !prod_valid_ff || prod_ready;

   always_comb begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
         for (int c = 0; c < NUM_COLS; c++) begin
            full[s][c]    = $signed(op_data.xval[s]) * $signed(op_data.opnd[s][c]);
            shf[s][c]     = full[s][c] >>> FRAC_BITS;
            prod_in[s][c] = shf[s][c][PW-1:0];
         end
      end
      info_in.row_index = op_data.row_index;
      info_in.base      = op_data.base;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else if (op_ready) begin
         prod_valid_ff <= op_valid;
      end
      if (op_ready && op_valid) begin
         prod_ff <= prod_in;
         info_ff <= info_in;
      end
   end

   assign prod_valid = prod_valid_ff;
   assign prod_info  = info_ff;
   assign prod_data  = prod_ff;

endmodule

>>> sv/nwr_accum.sv
// ----------------------------------------------------------------------------
// nwr_accum
// Saturating sum of the base row and the registered products in ascending
// column order, into the result register.
// ----------------------------------------------------------------------------
module nwr_accum import nwr_pkg::*; #(
   parameter int FRAC_BITS = 16,
   localparam int PW = 64 - FRAC_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   prod_valid,
   output logic                                   prod_ready,
   input  row_info_type                           prod_info,
   input  logic [NUM_SLOTS-1:0][NUM_COLS-1:0][PW-1:0] prod_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output rsp_type                                rsp_data
);

   logic     rsp_valid_ff;
   rsp_type  rsp_ff, rsp_in;
   mrow_type col;
   fix_type  acc;
   logic [PW:0]    sum;
   logic [PW-31:0] top;

   assign prod_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      col = '0;
      acc = '0;
      sum = '0;
      top = '0;
      for (int c = 0; c < NUM_COLS; c++) begin
         acc = prod_info.base[c];
         for (int s = 0; s < NUM_SLOTS; s++) begin
            sum = {{(PW+1-32){acc[31]}}, acc}
                + {prod_data[s][c][PW-1], prod_data[s][c]};
            top = sum[PW:31];
            if ((&top) || !(|top)) begin
               acc = sum[31:0];
            end else begin
               acc = sum[PW] ? FIX_MIN : FIX_MAX;
            end
         end
         col[c] = acc;
      end
      rsp_in.row_index = prod_info.row_index;
      rsp_in.last_row  = (prod_info.row_index == ROW_TZ);
      rsp_in.coef_mass = col[COL_MASS];
      rsp_in.coef_mcx  = col[COL_MCX];
      rsp_in.coef_mcy  = col[COL_MCY];
      rsp_in.coef_mcz  = col[COL_MCZ];
      rsp_in.coef_ixx  = col[COL_IXX];
      rsp_in.coef_ixy  = col[COL_IXY];
      rsp_in.coef_ixz  = col[COL_IXZ];
      rsp_in.coef_iyy  = col[COL_IYY];
      rsp_in.coef_iyz  = col[COL_IYZ];
      rsp_in.coef_izz  = col[COL_IZZ];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (prod_ready) begin
         rsp_valid_ff <= prod_valid;
      end
      if (prod_ready && prod_valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> sv/net_wrench_regressor_top.sv
// ----------------------------------------------------------------------------
// net_wrench_regressor_top
// Net-wrench inertial-parameter regressor: one twist and one twist
// acceleration in, the six rows of the 6x10 regressor out.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  req      in         req_valid/req_stall   req_type, twist and acceleration
//  rsp      out        rsp_valid/rsp_stall   rsp_type, one regressor row
//
//  each item gives six rows, one per cycle while rsp is not stalled; the
//  single result port sets that rate
//  the first row passes the item register, the product register and the
//  result register before it leaves
//  the next item is taken in the cycle the last row of the current one issues
//  reset is synchronous and clears the valid flags and the row counter
//  a stall on rsp backs up through the product stage to req_stall
// ----------------------------------------------------------------------------
module net_wrench_regressor_top import nwr_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int PW = 64 - FRAC_BITS;

   logic                                       op_valid, op_ready;
   op_type                                     op_data;
   logic                                       prod_valid, prod_ready;
   row_info_type                               prod_info;
   logic [NUM_SLOTS-1:0][NUM_COLS-1:0][PW-1:0] prod_data;

   nwr_issue u_issue (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .op_valid  (op_valid),
      .op_ready  (op_ready),
      .op_data   (op_data)
   );

   nwr_mult #(.FRAC_BITS(FRAC_BITS)) u_mult (
      .clock      (clock),
      .reset      (reset),
      .op_valid   (op_valid),
      .op_ready   (op_ready),
      .op_data    (op_data),
      .prod_valid (prod_valid),
      .prod_ready (prod_ready),
      .prod_info  (prod_info),
      .prod_data  (prod_data)
   );

   nwr_accum #(.FRAC_BITS(FRAC_BITS)) u_accum (
      .clock      (clock),
      .reset      (reset),
      .prod_valid (prod_valid),
      .prod_ready (prod_ready),
      .prod_info  (prod_info),
      .prod_data  (prod_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   // rows of one item follow each other in order
   a_next_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_data.last_row && prod_valid) |=>
      (rsp_valid && rsp_data.row_index == $past(rsp_data.row_index) + 3'd1))
      else $error("row sequence broken");

   // after the last row the next item starts at the first row
   a_wrap_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_data.last_row && prod_valid) |=>
      (rsp_valid && rsp_data.row_index == ROW_FX))
      else $error("item did not restart at first row");

   // a full pipe under output stall holds off the input
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      (op_valid && prod_valid && rsp_valid && rsp_stall) |-> req_stall)
      else $error("input taken while pipe is full");

endmodule
